### src/otgs_pkg.sv
// Shared types, constants and glyph address helpers for the text to glyph stream block.
// Used by all other src modules (the interfaces do not use it); depends on nothing.
package otgs_pkg;

  localparam int unsigned DISPLAY_WIDTH     = 128;
  localparam int unsigned GLYPH_STORE_DEPTH = 4096;
  localparam int unsigned STORE_AW          = $clog2(GLYPH_STORE_DEPTH);
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned QUEUE_AW          = $clog2(QUEUE_DEPTH);

  localparam logic [11:0] BASE_ASCII = 12'd0;
  localparam logic [11:0] BASE_RUS1  = 12'd1536;
  localparam logic [11:0] BASE_RUS2  = 12'd2304;
  localparam logic [11:0] BASE_RUS3  = 12'd2560;

  localparam logic [7:0] COUNT_ASCII = 8'd96;
  localparam logic [7:0] COUNT_RUS1  = 8'd48;
  localparam logic [7:0] COUNT_RUS2  = 8'd16;

  localparam logic [7:0] CHAR_END    = 8'd0;
  localparam logic [7:0] CHAR_LEAD_A = 8'd208;
  localparam logic [7:0] CHAR_LEAD_B = 8'd209;
  localparam logic [7:0] CHAR_RUS3_A = 8'd129;
  localparam logic [7:0] CHAR_RUS3_B = 8'd145;
  localparam logic [7:0] OFS_RUS1    = 8'd144;
  localparam logic [7:0] OFS_RUS2    = 8'd128;
  localparam logic [7:0] OFS_ASCII   = 8'd32;
  localparam logic [7:0] CHAR_HIGH   = 8'd128;

  localparam logic [7:0] CMD_PAGE   = 8'hb0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_COL_LO = 8'h01;

  localparam logic [2:0] MAX_ROW = 3'd3;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_TEXT  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_A    = 2'd1,
    LEAD_B    = 2'd2
  } lead_t;

  typedef enum logic {
    JOB_LOAD  = 1'b0,
    JOB_GLYPH = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [2:0]  page;
    logic [7:0]  column;
    logic        last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [11:0] ascii_base(logic [7:0] b);
    logic [7:0] g;
    g = (b > OFS_ASCII) ? 8'(b - OFS_ASCII) : 8'd0;
    if (g >= COUNT_ASCII) g = 8'd0;
    return BASE_ASCII + {g, 4'b0000};
  endfunction

  function automatic logic [11:0] pair_base(lead_t lead, logic [7:0] b);
    logic [7:0] g;
    g = 8'd0;
    if (lead == LEAD_A) begin
      if (b == CHAR_RUS3_A) return BASE_RUS3;
      g = (b > OFS_RUS1) ? 8'(b - OFS_RUS1) : 8'd0;
      if (g >= COUNT_RUS1) g = 8'd0;
      return BASE_RUS1 + {g, 4'b0000};
    end
    if (b == CHAR_RUS3_B) return BASE_RUS3 + 12'd16;
    g = (b > OFS_RUS2) ? 8'(b - OFS_RUS2) : 8'd0;
    if (g >= COUNT_RUS2) g = 8'd0;
    return BASE_RUS2 + {g, 4'b0000};
  endfunction

endpackage

### src/otgs_if.sv
// Valid/ready channel interfaces for input items and controller bytes.
// Stand-alone; no package dependency.
interface otgs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [11:0] glyph_address;
  logic [7:0]  glyph_byte;
  logic [2:0]  text_row;
  logic [7:0]  start_column;
  logic [7:0]  text_char;

  modport source(output valid, action, glyph_address, glyph_byte, text_row, start_column,
                 text_char, input ready);
  modport sink(input valid, action, glyph_address, glyph_byte, text_row, start_column,
               text_char, output ready);
endinterface

interface otgs_out_if;
  logic       valid;
  logic       ready;
  logic       is_command;
  logic [7:0] bus_byte;
  logic       last;

  modport source(output valid, is_command, bus_byte, last, input ready);
  modport sink(input valid, is_command, bus_byte, last, output ready);
endinterface

### src/otgs_queue.sv
// Short job queue between front end and back end.
// Depends on otgs_pkg for job_t and queue_stat_t.
module otgs_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  otgs_pkg::job_t        push_job,
  input  logic                  pop,
  output otgs_pkg::job_t        head_job,
  output otgs_pkg::queue_stat_t stat
);

  localparam int unsigned AW = otgs_pkg::QUEUE_AW;
  localparam int unsigned CW = otgs_pkg::QUEUE_AW + 1;

  otgs_pkg::job_t entry_r [otgs_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(otgs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(otgs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

  assign head_job   = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(otgs_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

### src/otgs_front.sv
// Front end: accepts items, tracks line state and turns them into load and glyph jobs.
// Depends on otgs_pkg and otgs_in_if.
module otgs_front (
  input  logic                  clk,
  input  logic                  rst_n,
  otgs_in_if.sink               in_chan,
  input  otgs_pkg::queue_stat_t stat,
  output logic                  push,
  output otgs_pkg::job_t        push_job
);

  logic [2:0]      page_r, page_nxt;
  logic [7:0]      column_r, column_nxt;
  logic            active_r, active_nxt;
  otgs_pkg::lead_t lead_r, lead_nxt;
  logic            second_valid_r, second_valid_nxt;
  otgs_pkg::job_t  second_job_r, second_job_nxt;

  logic            accept;
  logic            have_pair, have_ascii;
  otgs_pkg::job_t  pair_job, ascii_job;
  logic [8:0]      column_end;
  logic [7:0]      b;

  assign in_chan.ready = !second_valid_r && !stat.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.text_char;
  assign column_end    = {1'b0, column_r} + 9'd8;

  always_comb begin
    page_nxt         = page_r;
    column_nxt       = column_r;
    active_nxt       = active_r;
    lead_nxt         = lead_r;
    second_valid_nxt = second_valid_r;
    second_job_nxt   = second_job_r;
    push             = 1'b0;
    push_job         = '0;
    have_pair        = 1'b0;
    have_ascii       = 1'b0;
    pair_job  = '{kind: otgs_pkg::JOB_GLYPH, addr: otgs_pkg::pair_base(lead_r, b),
                  data: 8'd0, page: page_r, column: column_r, last: 1'b0};
    ascii_job = '{kind: otgs_pkg::JOB_GLYPH, addr: otgs_pkg::ascii_base(b),
                  data: 8'd0, page: page_r, column: column_r, last: 1'b1};

    if (second_valid_r && !stat.full) begin
      push             = 1'b1;
      push_job         = second_job_r;
      second_valid_nxt = 1'b0;
    end

    if (accept) begin
      unique case (otgs_pkg::action_t'(in_chan.action))
        otgs_pkg::ACT_LOAD: begin
          if (14'(in_chan.glyph_address) < 14'(otgs_pkg::GLYPH_STORE_DEPTH)) begin
            push     = 1'b1;
            push_job = '{kind: otgs_pkg::JOB_LOAD, addr: in_chan.glyph_address,
                         data: in_chan.glyph_byte, page: 3'd0, column: 8'd0, last: 1'b0};
          end
        end
        otgs_pkg::ACT_START: begin
          lead_nxt = otgs_pkg::LEAD_NONE;
          if (in_chan.text_row > otgs_pkg::MAX_ROW) begin
            active_nxt = 1'b0;
          end else begin
            active_nxt = 1'b1;
            page_nxt   = {in_chan.text_row[1:0], 1'b0};
            column_nxt = in_chan.start_column;
          end
        end
        otgs_pkg::ACT_TEXT: begin
          if (active_r) begin
            have_pair = (lead_r != otgs_pkg::LEAD_NONE);
            lead_nxt  = otgs_pkg::LEAD_NONE;
            if (b == otgs_pkg::CHAR_END) begin
              active_nxt = 1'b0;
            end else if (column_end > 9'(otgs_pkg::DISPLAY_WIDTH)) begin
              active_nxt = 1'b0;
            end else if (b < otgs_pkg::CHAR_HIGH) begin
              have_ascii = 1'b1;
              column_nxt = column_end[7:0];
            end else if (b == otgs_pkg::CHAR_LEAD_A) begin
              lead_nxt = otgs_pkg::LEAD_A;
            end else if (b == otgs_pkg::CHAR_LEAD_B) begin
              lead_nxt = otgs_pkg::LEAD_B;
            end else begin
              column_nxt = column_end[7:0];
            end
          end
        end
        default: begin
        end
      endcase

      if (have_pair && have_ascii) begin
        push             = 1'b1;
        push_job         = pair_job;
        second_valid_nxt = 1'b1;
        second_job_nxt   = ascii_job;
      end else if (have_pair) begin
        push          = 1'b1;
        push_job      = pair_job;
        push_job.last = 1'b1;
      end else if (have_ascii) begin
        push     = 1'b1;
        push_job = ascii_job;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r         <= '0;
      column_r       <= '0;
      active_r       <= 1'b0;
      lead_r         <= otgs_pkg::LEAD_NONE;
      second_valid_r <= 1'b0;
    end else begin
      page_r         <= page_nxt;
      column_r       <= column_nxt;
      active_r       <= active_nxt;
      lead_r         <= lead_nxt;
      second_valid_r <= second_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    second_job_r <= second_job_nxt;
  end

endmodule

### src/otgs_back.sv
// Back end: owns the glyph store and plays each glyph job out as 22 controller words.
// Depends on otgs_pkg and otgs_out_if.
module otgs_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  otgs_pkg::job_t        head_job,
  input  otgs_pkg::queue_stat_t stat,
  output logic                  pop,
  otgs_out_if.source            out_chan
);

  localparam int unsigned SAW      = otgs_pkg::STORE_AW;
  localparam logic [4:0] LAST_STEP = 5'd21;
  localparam logic [4:0] HALF_STEP = 5'd11;
  localparam logic [4:0] SETUP     = 5'd3;
  localparam logic [4:0] DATA_LEN  = 5'd8;

  logic [7:0]     glyph_mem_r [otgs_pkg::GLYPH_STORE_DEPTH];
  logic           busy_r, busy_nxt;
  logic [4:0]     step_r, step_nxt;
  otgs_pkg::job_t job_r, job_nxt;
  logic [7:0]     rd_r;
  logic           out_valid_r, out_valid_nxt;
  logic           out_cmd_r, out_cmd_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic           out_last_r, out_last_nxt;

  logic           adv, wr_en, rd_en, half;
  logic [4:0]     lstep, next_step, rd_ofs;
  logic [2:0]     page_h;
  logic [7:0]     beat_byte;
  logic [11:0]    rd_addr;

  assign adv   = !out_valid_r || out_chan.ready;
  assign pop   = !stat.empty && (!busy_r || (adv && step_r == LAST_STEP));
  assign wr_en = pop && head_job.kind == otgs_pkg::JOB_LOAD;
  assign rd_en = busy_r && adv;

  assign half      = (step_r >= HALF_STEP);
  assign lstep     = half ? step_r - HALF_STEP : step_r;
  assign page_h    = job_r.page + {2'b00, half};
  assign next_step = step_r + 5'd1;
  assign rd_ofs    = (next_step >= HALF_STEP + SETUP) ? next_step - HALF_STEP - SETUP + DATA_LEN
                                                      : next_step - SETUP;
  assign rd_addr   = job_r.addr + {8'd0, rd_ofs[3:0]};

  always_comb begin
    case (lstep)
      5'd0:    beat_byte = otgs_pkg::CMD_PAGE + {5'd0, page_h};
      5'd1:    beat_byte = otgs_pkg::CMD_COL_HI | {4'h0, job_r.column[7:4]};
      5'd2:    beat_byte = otgs_pkg::CMD_COL_LO | {4'h0, job_r.column[3:0]};
      default: beat_byte = rd_r;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r;
    out_cmd_nxt   = out_cmd_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = busy_r;
      out_cmd_nxt   = (lstep < SETUP);
      out_byte_nxt  = beat_byte;
      out_last_nxt  = job_r.last && (step_r == LAST_STEP);
    end
    if (busy_r && adv) begin
      if (step_r == LAST_STEP) busy_nxt = 1'b0;
      else step_nxt = next_step;
    end
    if (pop && head_job.kind == otgs_pkg::JOB_GLYPH) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      job_nxt  = head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) glyph_mem_r[SAW'(head_job.addr)] <= head_job.data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= glyph_mem_r[SAW'(rd_addr)];
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.is_command = out_cmd_r;
  assign out_chan.bus_byte   = out_byte_r;
  assign out_chan.last       = out_last_r;

endmodule

### src/text_to_oled_glyph_stream_core.sv
// Top level of the text to display glyph stream block.
// Depends on otgs_pkg, otgs_if, otgs_front, otgs_queue and otgs_back.
//
// Load items write the 4096 x 8 glyph store; a start item opens a text line; text bytes
// (ASCII or a 208/209 lead byte and its follower) each send one glyph as 22 words: page
// and column set-up commands then 8 data bytes, for two pages. The front end takes one
// item per cycle unless the four-entry job queue is full or a byte that sends both a
// pending Cyrillic glyph and an ASCII glyph still holds its second job. The back end
// sends one word per cycle while the output is ready; a load sends no words. The
// glyph store is not cleared by reset and entries must be loaded before they are shown.
module text_to_oled_glyph_stream_core (
  input logic        clk,
  input logic        rst_n,
  otgs_in_if.sink    in_chan,
  otgs_out_if.source out_chan
);

  logic                  fifo_push, fifo_pop;
  otgs_pkg::job_t        push_job, head_job;
  otgs_pkg::queue_stat_t fifo_stat;

  otgs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .stat     (fifo_stat),
    .push     (fifo_push),
    .push_job (push_job)
  );

  otgs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_job (push_job),
    .pop      (fifo_pop),
    .head_job (head_job),
    .stat     (fifo_stat)
  );

  otgs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .stat     (fifo_stat),
    .pop      (fifo_pop),
    .out_chan (out_chan)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_stat.full)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_stat.empty)
    else $error("job popped from empty queue");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last) |-> !out_chan.is_command)
    else $error("last word is not a data byte");

endmodule
